// ===== hw/rtl/oale_pkg.sv =====
package oale_pkg;

    // Stream payload widths
    localparam int IN_W  = 40;
    localparam int OUT_W = 48;

    // Parameter default and the widest count any legal capacity needs
    localparam int CAPACITY_DEFAULT = 16;
    localparam int CNT_W            = 7;
    localparam int READ_LIMIT       = 16;

    // Command queue between front and back
    localparam int QDEPTH = 2;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_INSERT = 3'd2;
    localparam logic [2:0] CMD_DELETE = 3'd3;
    localparam logic [2:0] CMD_SEARCH = 3'd4;
    localparam logic [2:0] CMD_READ   = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // Work left for the back part once the front has checked the command
    typedef enum logic [2:0] {
        K_REPORT = 3'd0,
        K_APPEND = 3'd1,
        K_INSERT = 3'd2,
        K_DELETE = 3'd3,
        K_SEARCH = 3'd4,
        K_READ   = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [4:0]         pos;
        logic [31:0]        value;
        logic [2:0]         status;
        logic [CNT_W-1:0]   cnt;
        logic [CNT_W-1:0]   cnt_after;
    } t_op;

    typedef struct packed {
        logic [4:0]  list_count;
        logic [31:0] element;
        logic [3:0]  found_index;
        logic [2:0]  status;
    } t_res;

endpackage

// ===== hw/rtl/ordered_array_list_engine_top.sv =====
// Bounded ordered list of up to CAPACITY signed 32-bit values. Each input
// transaction carries one command (clear, append, insert, delete, search,
// read out); every command answers with one result, except read out, which
// returns one result per entry (at most sixteen) with tlast on the final one.
// Codes 6 and 7 are taken and dropped without a result. The front checks
// each command against its own copy of the entry count and queues it; a
// queued command is taken by the back once the back is idle. The back
// runs it against a one-read, one-write entry memory. Clear, append and
// error results go straight to the result register. Insert, delete and
// search step one entry at a time through the single read and write port:
// insert moves the entries from the end down to the position up by one and
// then writes the value, delete moves the entries above the position down,
// and search reads from the front to the first match. Read out gives one
// result per cycle while the output is not stalled. Up to two commands wait
// in the queue, so the input can run two ahead of the back before tready drops.
module ordered_array_list_engine_top #(
    parameter int CAPACITY = oale_pkg::CAPACITY_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // command[2:0], position[7:3], value[39:8]
    input  logic [oale_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // status[2:0], found_index[6:3], element[38:7], list_count[43:39], zero[47:44]
    output logic [oale_pkg::OUT_W-1:0] o_m_axis_tdata,
    output logic                       o_m_axis_tlast
);
    import oale_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_op  front_op;
    t_op  back_op;
    t_res res;

    oale_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_cmd    (i_s_axis_tdata[2:0]),
        .i_pos    (i_s_axis_tdata[7:3]),
        .i_value  (i_s_axis_tdata[39:8]),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_op     (front_op)
    );

    oale_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (back_op),
        .o_empty (q_empty)
    );

    oale_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (!q_empty),
        .i_op       (back_op),
        .o_op_pop   (q_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_res      (res),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'b0000, res};

    // Any error or not-found answer is a single result
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[2:0] != ST_OK)) |-> o_m_axis_tlast)
        else $error("error result without tlast");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command queue underflow");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

// ===== hw/rtl/oale_front.sv =====
module oale_front #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [2:0]    i_cmd,
    input  logic [4:0]    i_pos,
    input  logic [31:0]   i_value,
    input  logic          i_q_full,
    output logic          o_push,
    output oale_pkg::t_op o_op
);
    import oale_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]    r_cnt, n_cnt;
    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic [CNT_W-1:0] cnt_w;
    logic [CNT_W-1:0] pos_w;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && !i_q_full;
    assign is_full  = (r_cnt == CW'(CAPACITY));
    assign is_empty = (r_cnt == '0);
    assign cnt_w    = CNT_W'(r_cnt);
    assign pos_w    = CNT_W'(i_pos);

    always_comb begin
        o_push         = 1'b0;
        o_op.kind      = K_REPORT;
        o_op.pos       = i_pos;
        o_op.value     = i_value;
        o_op.status    = ST_OK;
        o_op.cnt       = cnt_w;
        o_op.cnt_after = cnt_w;
        n_cnt          = r_cnt;
        unique case (i_cmd)
            CMD_CLEAR: begin
                o_push         = accept;
                o_op.cnt_after = '0;
                n_cnt          = '0;
            end
            CMD_APPEND: begin
                o_push = accept;
                if (is_full) begin
                    o_op.status = ST_FULL;
                end else begin
                    o_op.kind      = K_APPEND;
                    o_op.cnt_after = CNT_W'(cnt_w + 1'b1);
                    n_cnt          = CW'(r_cnt + 1'b1);
                end
            end
            CMD_INSERT: begin
                o_push = accept;
                priority if (is_full) begin
                    o_op.status = ST_FULL;
                end else if (pos_w > cnt_w) begin
                    o_op.status = ST_INVALID;
                end else begin
                    o_op.kind      = K_INSERT;
                    o_op.cnt_after = CNT_W'(cnt_w + 1'b1);
                    n_cnt          = CW'(r_cnt + 1'b1);
                end
            end
            CMD_DELETE: begin
                o_push = accept;
                priority if (is_empty) begin
                    o_op.status = ST_EMPTY;
                end else if (pos_w >= cnt_w) begin
                    o_op.status = ST_INVALID;
                end else begin
                    o_op.kind      = K_DELETE;
                    o_op.cnt_after = CNT_W'(cnt_w - 1'b1);
                    n_cnt          = CW'(r_cnt - 1'b1);
                end
            end
            CMD_SEARCH: begin
                o_push = accept;
                if (is_empty) begin
                    o_op.status = ST_EMPTY;
                end else begin
                    // back part turns this into OK on a match
                    o_op.kind   = K_SEARCH;
                    o_op.status = ST_NOT_FOUND;
                end
            end
            CMD_READ: begin
                o_push = accept;
                if (is_empty) begin
                    o_op.status = ST_EMPTY;
                end else begin
                    o_op.kind = K_READ;
                end
            end
            default: begin
                // unused codes: take the transaction and drop it
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/oale_queue.sv =====
module oale_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  oale_pkg::t_op i_data,
    output logic          o_full,
    input  logic          i_pop,
    output oale_pkg::t_op o_data,
    output logic          o_empty
);
    import oale_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int FW = $clog2(QDEPTH + 1);

    t_op           r_buf [QDEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [FW-1:0] r_fill;

    assign o_full  = (r_fill == FW'(QDEPTH));
    assign o_empty = (r_fill == '0);
    assign o_data  = r_buf[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(QDEPTH - 1)) ? '0 : PW'(r_wptr + 1'b1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(QDEPTH - 1)) ? '0 : PW'(r_rptr + 1'b1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_fill <= FW'(r_fill + 1'b1);
                2'b01:   r_fill <= FW'(r_fill - 1'b1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// ===== hw/rtl/oale_back.sv =====
module oale_back #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    input  oale_pkg::t_op i_op,
    output logic          o_op_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output oale_pkg::t_res o_res,
    output logic          o_last
);
    import oale_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INS  = 6'b000010,
        S_DEL  = 6'b000100,
        S_SRCH = 6'b001000,
        S_RD   = 6'b010000,
        S_RESP = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_wa, n_wa;
    logic          r_pend, n_pend;
    logic [CW-1:0] r_pos, n_pos;
    logic [31:0]   r_value, n_value;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_cnt_after, n_cnt_after;
    logic [CW-1:0] r_lim, n_lim;
    logic [2:0]    r_status, n_status;
    logic [3:0]    r_idx, n_idx;

    logic [31:0]   r_mem [CAPACITY];
    logic [31:0]   r_rdata;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata;

    logic          r_out_valid;
    t_res          r_out;
    logic          r_out_last;
    logic          load;
    t_res          ld_res;
    logic          ld_last;
    logic          out_free;

    logic [CW-1:0]    ptr_inc, ptr_dec, wa_inc;
    logic [CNT_W-1:0] lim_w;

    assign out_free = !r_out_valid || i_ready;
    assign ptr_inc  = CW'(r_ptr + 1'b1);
    assign ptr_dec  = CW'(r_ptr - 1'b1);
    assign wa_inc   = CW'(r_wa + 1'b1);
    assign lim_w    = (i_op.cnt > CNT_W'(READ_LIMIT)) ? CNT_W'(READ_LIMIT) : i_op.cnt;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_wa        = r_wa;
        n_pend      = r_pend;
        n_pos       = r_pos;
        n_value     = r_value;
        n_cnt       = r_cnt;
        n_cnt_after = r_cnt_after;
        n_lim       = r_lim;
        n_status    = r_status;
        n_idx       = r_idx;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        re          = 1'b0;
        raddr       = '0;
        o_op_pop    = 1'b0;
        load        = 1'b0;
        ld_res      = '0;
        ld_last     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    o_op_pop    = 1'b1;
                    n_value     = i_op.value;
                    n_pos       = CW'(i_op.pos);
                    n_cnt       = CW'(i_op.cnt);
                    n_cnt_after = CW'(i_op.cnt_after);
                    n_status    = i_op.status;
                    n_idx       = '0;
                    n_pend      = 1'b0;
                    n_lim       = CW'(lim_w);
                    unique case (i_op.kind)
                        K_REPORT: n_state = S_RESP;
                        K_APPEND: begin
                            we      = 1'b1;
                            waddr   = i_op.cnt[AW-1:0];
                            wdata   = i_op.value;
                            n_state = S_RESP;
                        end
                        K_INSERT: begin
                            n_ptr   = CW'(i_op.cnt);
                            n_state = S_INS;
                        end
                        K_DELETE: begin
                            n_ptr   = CW'(i_op.pos);
                            n_state = S_DEL;
                        end
                        K_SEARCH: begin
                            n_ptr   = '0;
                            n_state = S_SRCH;
                        end
                        K_READ: begin
                            n_ptr   = '0;
                            n_state = S_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                // walk down from the end, one entry moved up per cycle
                if (r_pend) begin
                    we    = 1'b1;
                    waddr = r_wa[AW-1:0];
                    wdata = r_rdata;
                end
                if (r_ptr > r_pos) begin
                    re     = 1'b1;
                    raddr  = ptr_dec[AW-1:0];
                    n_pend = 1'b1;
                    n_wa   = r_ptr;
                    n_ptr  = ptr_dec;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        we      = 1'b1;
                        waddr   = r_pos[AW-1:0];
                        wdata   = r_value;
                        n_state = S_RESP;
                    end
                end
            end
            S_DEL: begin
                if (r_pend) begin
                    we    = 1'b1;
                    waddr = r_wa[AW-1:0];
                    wdata = r_rdata;
                end
                if (ptr_inc < r_cnt) begin
                    re     = 1'b1;
                    raddr  = ptr_inc[AW-1:0];
                    n_pend = 1'b1;
                    n_wa   = r_ptr;
                    n_ptr  = ptr_inc;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SRCH: begin
                priority if (r_pend && (r_rdata == r_value)) begin
                    n_status = ST_OK;
                    n_idx    = 4'(r_wa);
                    n_pend   = 1'b0;
                    n_state  = S_RESP;
                end else if (r_ptr < r_cnt) begin
                    re     = 1'b1;
                    raddr  = r_ptr[AW-1:0];
                    n_pend = 1'b1;
                    n_wa   = r_ptr;
                    n_ptr  = ptr_inc;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_RESP;
                    end
                end
            end
            S_RD: begin
                if (r_pend && out_free) begin
                    load               = 1'b1;
                    ld_res.status      = ST_OK;
                    ld_res.found_index = 4'(r_wa);
                    ld_res.element     = r_rdata;
                    ld_res.list_count  = 5'(r_cnt);
                    ld_last            = (wa_inc == r_lim);
                end
                // fetch the next entry only once the held one is on its way
                if ((r_ptr < r_lim) && (!r_pend || out_free)) begin
                    re     = 1'b1;
                    raddr  = r_ptr[AW-1:0];
                    n_pend = 1'b1;
                    n_wa   = r_ptr;
                    n_ptr  = ptr_inc;
                end else if (r_pend && out_free) begin
                    n_pend = 1'b0;
                end
                if ((r_ptr >= r_lim) && (!r_pend || out_free)) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    load               = 1'b1;
                    ld_res.status      = r_status;
                    ld_res.found_index = r_idx;
                    ld_res.element     = '0;
                    ld_res.list_count  = 5'(r_cnt_after);
                    ld_last            = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_wa        <= n_wa;
        r_pos       <= n_pos;
        r_value     <= n_value;
        r_cnt       <= n_cnt;
        r_cnt_after <= n_cnt_after;
        r_lim       <= n_lim;
        r_status    <= n_status;
        r_idx       <= n_idx;
        if (load) begin
            r_out      <= ld_res;
            r_out_last <= ld_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_last  = r_out_last;

endmodule

// ===== dv/ordered_array_list_engine_top_test.sv =====
module ordered_array_list_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import oale_pkg::*;

    localparam int CAP          = CAPACITY_DEFAULT;
    localparam int RANDOM_ITEMS = 145;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    // Codes the block takes and drops without a result
    localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic last;
        t_res res;
    } t_list_result;

    class t_list_board;
        logic [31:0]  entries [CAP];
        int unsigned  fill;
        t_list_result pending_results[$];
        int           errors;
        int           checked;
        int           noted;
        int           dropped;
        int           full_rejects;
        int           read_outs;

        function void push_result(input logic [2:0] status, input logic [3:0] idx,
                                  input logic [31:0] elem, input logic last);
            t_list_result r;
            r.res.status      = status;
            r.res.found_index = idx;
            r.res.element     = elem;
            r.res.list_count  = 5'(fill);
            r.last            = last;
            pending_results.push_back(r);
        endfunction

        function void note_command(input logic [2:0] cmd, input logic [4:0] pos,
                                   input logic [31:0] val);
            logic [2:0]  status;
            logic [3:0]  idx;
            int unsigned i;
            int unsigned n;
            status = ST_OK;
            idx    = '0;
            noted++;
            case (cmd)
                CMD_CLEAR: begin
                    fill = 0;
                end
                CMD_APPEND: begin
                    if (fill >= CAP) begin
                        status = ST_FULL;
                    end else begin
                        entries[fill] = val;
                        fill++;
                    end
                end
                CMD_INSERT: begin
                    if (fill >= CAP) begin
                        status = ST_FULL;
                    end else if (pos > fill) begin
                        status = ST_INVALID;
                    end else begin
                        for (i = fill; i > pos; i--)
                            entries[i] = entries[i - 1];
                        entries[pos] = val;
                        fill++;
                    end
                end
                CMD_DELETE: begin
                    if (fill == 0) begin
                        status = ST_EMPTY;
                    end else if (pos >= fill) begin
                        status = ST_INVALID;
                    end else begin
                        for (i = pos; i + 1 < fill; i++)
                            entries[i] = entries[i + 1];
                        fill--;
                    end
                end
                CMD_SEARCH: begin
                    if (fill == 0) begin
                        status = ST_EMPTY;
                    end else begin
                        status = ST_NOT_FOUND;
                        for (i = 0; i < fill; i++) begin
                            if (entries[i] == val) begin
                                status = ST_OK;
                                idx    = 4'(i);
                                break;
                            end
                        end
                    end
                end
                CMD_READ: begin
                    if (fill == 0) begin
                        status = ST_EMPTY;
                    end else begin
                        n = (fill < READ_LIMIT) ? fill : READ_LIMIT;
                        read_outs++;
                        for (i = 0; i < n; i++)
                            push_result(ST_OK, 4'(i), entries[i], (i + 1 == n));
                        return;
                    end
                end
                default: begin
                    dropped++;
                    return;
                end
            endcase
            if (status == ST_FULL)
                full_rejects++;
            push_result(status, idx, '0, 1'b1);
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input logic [OUT_W-1:0] data, input logic last);
            t_list_result want;
            t_res         got;
            got = data[$bits(t_res)-1:0];
            checked++;
            if (pending_results.size() == 0) begin
                $error("result with no command waiting: tdata 0x%0h tlast %0b", data, last);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", 32'(want.res.status), 32'(got.status));
            compare_field("found_index", 32'(want.res.found_index), 32'(got.found_index));
            compare_field("element", want.res.element, got.element);
            compare_field("list_count", 32'(want.res.list_count), 32'(got.list_count));
            compare_field("last", 32'(want.last), 32'(last));
            compare_field("padding", 32'd0, 32'(data[OUT_W-1:$bits(t_res)]));
        endfunction
    endclass

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata  = '0;  // command, position, value
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;        // status, found_index, element, list_count
    logic             o_m_axis_tlast;

    t_list_board      board = new;
    int               stall_mode = 0;
    int               rx_cycle   = 0;
    int               idle_cycles = 0;

    ordered_array_list_engine_top #(
        .CAPACITY(CAP)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: switch among four stall patterns, picked at random
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 48 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       i_m_axis_tready <= 1'b1;
            1:       i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       i_m_axis_tready <= ($urandom_range(0, 2) == 0);
            default: i_m_axis_tready <= ((rx_cycle % 6) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_result(o_m_axis_tdata, o_m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_command(input logic [2:0] cmd, input logic [4:0] pos,
                                input logic [31:0] val);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {val, pos, cmd};
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_command(cmd, pos, val);
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    initial begin
        int          sent;
        int          burst_left;
        int          gap;
        int          pick;
        bit          drained;
        logic [2:0]  cmd;
        logic [4:0]  pos;
        logic [31:0] val;

        sent       = 0;
        burst_left = 0;
        drained    = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty list corners, dropped codes and position errors on a short list
        send_command(CMD_READ, 5'd0, 32'd0);
        send_command(CMD_DELETE, 5'd0, 32'd0);
        send_command(CMD_SEARCH, 5'd0, 32'd0);
        send_command(CMD_INSERT, 5'd1, 32'd5);
        send_command(CMD_UNUSED_6, 5'd31, 32'hffff_ffff);
        send_command(CMD_UNUSED_7, 5'd0, 32'd0);
        send_command(CMD_INSERT, 5'd0, 32'h8000_0000);
        send_command(CMD_APPEND, 5'd0, 32'h7fff_ffff);
        send_command(CMD_INSERT, 5'd1, 32'hffff_ffff);
        send_command(CMD_SEARCH, 5'd0, 32'h7fff_ffff);
        send_command(CMD_SEARCH, 5'd0, 32'd12345);
        send_command(CMD_DELETE, 5'd3, 32'd0);
        send_command(CMD_DELETE, 5'd31, 32'd0);
        send_command(CMD_DELETE, 5'd1, 32'd0);
        send_command(CMD_INSERT, 5'd2, 32'd0);
        // Fill up, with a duplicate of the first entry to check first-match search
        send_command(CMD_APPEND, 5'd0, 32'h8000_0000);
        while (board.fill < CAP)
            send_command(CMD_APPEND, 5'($urandom), $urandom);
        send_command(CMD_APPEND, 5'd0, 32'd1);
        send_command(CMD_INSERT, 5'd31, 32'd1);
        send_command(CMD_READ, 5'd0, 32'd0);
        send_command(CMD_SEARCH, 5'd0, board.entries[CAP-1]);
        send_command(CMD_SEARCH, 5'd0, 32'h8000_0000);
        send_command(CMD_DELETE, 5'd15, 32'd0);
        send_command(CMD_DELETE, 5'd15, 32'd0);
        send_command(CMD_CLEAR, 5'd0, 32'd0);

        while (sent < RANDOM_ITEMS) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap > 0)
                    idle_sender(gap);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;

            // Hold off once until the block has answered everything
            if (sent >= RANDOM_ITEMS / 2 && !drained) begin
                idle_sender(1);
                while (board.pending_results.size() != 0)
                    @(posedge i_clk);
                drained = 1'b1;
            end

            pick = $urandom_range(0, 99);
            if (pick < 3)       cmd = CMD_CLEAR;
            else if (pick < 6)  cmd = $urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
            else if (pick < 30) cmd = CMD_APPEND;
            else if (pick < 50) cmd = CMD_INSERT;
            else if (pick < 68) cmd = CMD_DELETE;
            else if (pick < 84) cmd = CMD_SEARCH;
            else                cmd = CMD_READ;

            if ($urandom_range(0, 4) == 0)
                pos = 5'($urandom_range(0, 31));
            else
                pos = 5'($urandom_range(0, board.fill));

            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 3))
                        0:       val = 32'h8000_0000;
                        1:       val = 32'h7fff_ffff;
                        2:       val = 32'h0000_0000;
                        default: val = 32'hffff_ffff;
                    endcase
                end
                1, 2, 3: begin
                    if (board.fill > 0)
                        val = board.entries[$urandom_range(0, board.fill - 1)];
                    else
                        val = $urandom;
                end
                4, 5:    val = $urandom_range(0, 15) - 8;
                default: val = $urandom;
            endcase

            send_command(cmd, pos, val);
            if (cmd != CMD_UNUSED_6 && cmd != CMD_UNUSED_7)
                sent++;
        end

        idle_sender(1);
        while (board.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d commands sent (%0d with dropped codes), %0d results checked",
                 board.noted, board.dropped, board.checked);
        $display("summary: %0d full rejects, %0d non-empty read-outs, %0d mismatches",
                 board.full_rejects, board.read_outs, board.errors);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
